// ===== rtl/core/acia_serial_register_model_macros.svh =====
// assertion macros for the acia serial register block
`ifndef ACIA_SERIAL_REGISTER_MODEL_MACROS_SVH
`define ACIA_SERIAL_REGISTER_MODEL_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ACIA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("acia check failed");
`define ACIA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("acia check failed");
`else
`define ACIA_ASSERT_NOW(label, pre, post)
`define ACIA_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/core/acia_pkg.sv =====
// shared types, codes and constants of the acia serial register block
`default_nettype none
package acia_pkg;

    localparam int PERIOD_BITS_DEF = 24;

    localparam int CLOCK_BITS    = 22;
    localparam int CENTI_BITS    = 7;
    localparam int DIVIDEND_BITS = CLOCK_BITS + CENTI_BITS;
    localparam int DIVISOR_BITS  = 21;

    localparam logic [CLOCK_BITS-1:0] CLOCK_RESET    = 22'd985248;
    localparam logic [CENTI_BITS-1:0] CENTI_SCALE    = 7'd100;
    localparam int                    PERIOD_RESET   = 985248 / 10;
    localparam logic [1:0]            IRQ_KIND_RESET = 2'd1;

    // config register indexes
    localparam logic CFG_CLOCK_HZ = 1'b0;
    localparam logic CFG_IRQ_KIND = 1'b1;

    localparam logic [1:0] IRQ_KIND_IRQ = 2'd1;
    localparam logic [1:0] IRQ_KIND_NMI = 2'd2;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] REG_DATA    = 2'd0;
    localparam logic [1:0] REG_STATUS  = 2'd1;
    localparam logic [1:0] REG_COMMAND = 2'd2;
    localparam logic [1:0] REG_CONTROL = 2'd3;

    localparam logic [7:0] ST_OVRN       = 8'h04;
    localparam logic [7:0] ST_RDRF       = 8'h08;
    localparam logic [7:0] ST_TDRE       = 8'h10;
    localparam logic [7:0] ST_TDRE_CLR   = 8'hef;
    localparam logic [7:0] ST_IRQ_FLAG   = 8'h80;
    localparam logic [7:0] CMD_ENABLE    = 8'h01;
    localparam logic [7:0] CMD_RXIRQ_DIS = 8'h02;
    localparam logic [7:0] CMD_TXIRQ_MSK = 8'h0c;
    localparam logic [7:0] CMD_TXIRQ_ON  = 8'h04;
    localparam logic [7:0] CMD_KEEP      = 8'he0;

    // operations of the register unit
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_READ   = 3'd1;
    localparam logic [2:0] OP_STORE  = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_PERIOD = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] sel;
        logic [7:0] data;
        logic       early;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_core_cmd;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
        logic       irq_next;
        logic [7:0] last_read;
    } t_core_rsp;

    // baud rates in hundredths of a baud
    function automatic logic [DIVISOR_BITS-1:0] baud_centi(input logic [3:0] sel);
        logic [DIVISOR_BITS-1:0] v;
        case (sel)
            4'd0:    v = 21'd1000;
            4'd1:    v = 21'd5000;
            4'd2:    v = 21'd7500;
            4'd3:    v = 21'd10992;
            4'd4:    v = 21'd13458;
            4'd5:    v = 21'd15000;
            4'd6:    v = 21'd30000;
            4'd7:    v = 21'd60000;
            4'd8:    v = 21'd120000;
            4'd9:    v = 21'd180000;
            4'd10:   v = 21'd240000;
            4'd11:   v = 21'd360000;
            4'd12:   v = 21'd480000;
            4'd13:   v = 21'd720000;
            4'd14:   v = 21'd960000;
            default: v = 21'd1920000;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/acia_div.sv =====
// shift-subtract divider, one quotient bit per cycle
`default_nettype none
module acia_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    input  wire logic [acia_pkg::DIVIDEND_BITS-1:0] i_dividend,
    input  wire logic [acia_pkg::DIVISOR_BITS-1:0]  i_divisor,
    output logic                                    o_busy,
    output logic                                    o_done,
    output logic [acia_pkg::DIVIDEND_BITS-1:0]      o_quotient
);
    localparam int DVD = acia_pkg::DIVIDEND_BITS;
    localparam int DVS = acia_pkg::DIVISOR_BITS;
    localparam int CW  = $clog2(DVD + 1);

    logic [DVD-1:0] r_dvd;
    logic [DVS:0]   r_rem;
    logic [DVS-1:0] r_dvs;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;

    logic [DVS:0]   rem_sh;
    logic           ge;
    logic [DVS:0]   n_rem;
    logic [DVD-1:0] n_dvd;

    always_comb begin
        rem_sh = {r_rem[DVS-1:0], r_dvd[DVD-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_rem  = ge ? rem_sh - {1'b0, r_dvs} : rem_sh;
        n_dvd  = {r_dvd[DVD-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DVD);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_dvd;
endmodule
`default_nettype wire

// ===== rtl/core/acia_regs.sv =====
// acia register file with read, store and character timer operations
`default_nettype none
module acia_regs #(
    parameter int PERIOD_BITS = acia_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire acia_pkg::t_core_cmd    i_cmd,
    input  wire logic [PERIOD_BITS-1:0] i_period,
    output acia_pkg::t_core_rsp         o_rsp
);
    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_WAITING = 2'd2;
    localparam logic [PERIOD_BITS-1:0] ONE = PERIOD_BITS'(1);

    logic [7:0]             r_cmd, n_cmd;
    logic [7:0]             r_ctrl, n_ctrl;
    logic [7:0]             r_status, n_status;
    logic [7:0]             r_rx_data, n_rx_data;
    logic [7:0]             r_tx_data, n_tx_data;
    logic [1:0]             r_phase, n_phase;
    logic                   r_irq, n_irq;
    logic                   r_line_open, n_line_open;
    logic                   r_timer_run, n_timer_run;
    logic [PERIOD_BITS-1:0] r_timer_cnt, n_timer_cnt;
    logic [PERIOD_BITS-1:0] r_char_period, n_char_period;
    logic [7:0]             r_last_read, n_last_read;

    logic [PERIOD_BITS-1:0] cnt_dec;
    logic                   expire;
    logic                   take;
    logic [7:0]             rd;

    function automatic logic [PERIOD_BITS-1:0] timer_load(
        input logic [PERIOD_BITS-1:0] n,
        input logic                   early
    );
        logic [PERIOD_BITS-1:0] m;
        m = (early && (n != '0)) ? n - ONE : n;
        return (m == '0) ? ONE : m;
    endfunction

    always_comb begin
        n_cmd         = r_cmd;
        n_ctrl        = r_ctrl;
        n_status      = r_status;
        n_rx_data     = r_rx_data;
        n_tx_data     = r_tx_data;
        n_phase       = r_phase;
        n_irq         = r_irq;
        n_line_open   = r_line_open;
        n_timer_run   = r_timer_run;
        n_timer_cnt   = r_timer_cnt;
        n_char_period = r_char_period;
        n_last_read   = r_last_read;
        cnt_dec       = (r_timer_cnt != '0) ? r_timer_cnt - ONE : r_timer_cnt;
        expire        = (cnt_dec == '0);
        take          = 1'b0;
        rd            = 8'h00;
        o_rsp         = '0;

        unique case (i_cmd.op)
            acia_pkg::OP_READ: begin
                unique case (i_cmd.sel)
                    acia_pkg::REG_DATA: begin
                        n_status = r_status & ~acia_pkg::ST_RDRF;
                        rd       = r_rx_data;
                    end
                    acia_pkg::REG_STATUS: begin
                        rd    = r_status | (r_irq ? acia_pkg::ST_IRQ_FLAG : 8'h00);
                        n_irq = 1'b0;
                    end
                    acia_pkg::REG_COMMAND: rd = r_cmd;
                    default:               rd = r_ctrl;
                endcase
                n_last_read     = rd;
                o_rsp.read_data = rd;
            end
            acia_pkg::OP_STORE: begin
                unique case (i_cmd.sel)
                    acia_pkg::REG_DATA: begin
                        n_tx_data = i_cmd.data;
                        if ((r_cmd & acia_pkg::CMD_ENABLE) != 8'h00) begin
                            if (r_phase == PH_IDLE) begin
                                n_timer_cnt = timer_load(ONE, i_cmd.early);
                                n_timer_run = 1'b1;
                                n_phase     = PH_WAITING;
                            end else if (r_phase != PH_WAITING) begin
                                n_phase = PH_WAITING;
                            end
                            n_status = r_status & acia_pkg::ST_TDRE_CLR;
                        end
                    end
                    acia_pkg::REG_STATUS: begin
                        n_line_open = 1'b0;
                        n_status    = r_status & ~acia_pkg::ST_OVRN;
                        n_cmd       = r_cmd & acia_pkg::CMD_KEEP;
                        n_phase     = PH_IDLE;
                        n_irq       = 1'b0;
                        n_timer_run = 1'b0;
                    end
                    acia_pkg::REG_COMMAND: begin
                        n_cmd = i_cmd.data;
                        if (i_cmd.data[0] && !r_line_open) begin
                            n_line_open = 1'b1;
                            n_timer_cnt = timer_load(r_char_period, i_cmd.early);
                            n_timer_run = 1'b1;
                        end else if (r_line_open && !i_cmd.data[0]) begin
                            n_line_open = 1'b0;
                            n_timer_run = 1'b0;
                        end
                    end
                    default: n_ctrl = i_cmd.data;
                endcase
            end
            acia_pkg::OP_TICK: begin
                if (r_timer_run) begin
                    n_timer_cnt = cnt_dec;
                    if (expire) begin
                        if ((r_phase == PH_WAITING) && r_line_open) begin
                            o_rsp.tx_valid = 1'b1;
                            o_rsp.tx_byte  = r_tx_data;
                        end
                        if (r_phase != PH_IDLE) begin
                            n_phase = r_phase - 2'd1;
                        end
                        take = r_line_open && ((r_status & acia_pkg::ST_RDRF) == 8'h00)
                               && i_cmd.rx_valid;
                        n_status = r_status | acia_pkg::ST_TDRE;
                        if (take) begin
                            n_rx_data = i_cmd.rx_byte;
                            n_status  = r_status | acia_pkg::ST_TDRE | acia_pkg::ST_RDRF;
                        end
                        if ((take && ((r_cmd & acia_pkg::CMD_RXIRQ_DIS) == 8'h00)) ||
                            ((r_cmd & acia_pkg::CMD_TXIRQ_MSK) == acia_pkg::CMD_TXIRQ_ON)) begin
                            n_irq = 1'b1;
                        end
                        n_timer_cnt = timer_load(r_char_period, 1'b0);
                        o_rsp.rx_taken = take;
                    end
                end
            end
            acia_pkg::OP_PERIOD: n_char_period = i_period;
            default: ;
        endcase

        o_rsp.irq_next  = n_irq;
        o_rsp.last_read = r_last_read;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd         <= 8'h00;
            r_ctrl        <= 8'h00;
            r_status      <= acia_pkg::ST_TDRE;
            r_rx_data     <= 8'h00;
            r_tx_data     <= 8'h00;
            r_phase       <= PH_IDLE;
            r_irq         <= 1'b0;
            r_line_open   <= 1'b0;
            r_timer_run   <= 1'b0;
            r_timer_cnt   <= '0;
            r_char_period <= PERIOD_BITS'(acia_pkg::PERIOD_RESET);
            r_last_read   <= 8'h00;
        end else begin
            r_cmd         <= n_cmd;
            r_ctrl        <= n_ctrl;
            r_status      <= n_status;
            r_rx_data     <= n_rx_data;
            r_tx_data     <= n_tx_data;
            r_phase       <= n_phase;
            r_irq         <= n_irq;
            r_line_open   <= n_line_open;
            r_timer_run   <= n_timer_run;
            r_timer_cnt   <= n_timer_cnt;
            r_char_period <= n_char_period;
            r_last_read   <= n_last_read;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/acia_serial_register_model.sv =====
// top level of the acia serial register block: sequencer, config and result register
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_stall    i_mode i_reg_select i_write_data i_rmw
//                                            i_rx_valid i_rx_byte
//  result    out        o_valid / i_stall    o_read_data o_tx_valid o_tx_byte
//                                            o_rx_taken o_irq_out o_nmi_out
//  config    in         i_cfg_we             i_cfg_idx i_cfg_data
//
//  reads, ticks, unused codes and plain writes complete as they are accepted
//  read-modify-write stores issue two stores, the last read byte and then the write data
//  a control write waits in S_DIV for the 29-step divider
//  reset is synchronous; no clearing pass, the block is ready right after reset
//  a held result stalls the input side until it is taken
`default_nettype none
`include "acia_serial_register_model_macros.svh"
module acia_serial_register_model #(
    parameter int PERIOD_BITS = acia_pkg::PERIOD_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [1:0]                      i_reg_select,
    input  wire logic [7:0]                      i_write_data,
    input  wire logic                            i_rmw,
    input  wire logic                            i_rx_valid,
    input  wire logic [7:0]                      i_rx_byte,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [7:0]                           o_read_data,
    output logic                                 o_tx_valid,
    output logic [7:0]                           o_tx_byte,
    output logic                                 o_rx_taken,
    output logic                                 o_irq_out,
    output logic                                 o_nmi_out,
    input  wire logic                            i_cfg_we,
    input  wire logic                            i_cfg_idx,
    input  wire logic [acia_pkg::CLOCK_BITS-1:0] i_cfg_data
);
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_STORE2 = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;

    localparam logic [32:0] PERIOD_MAX = (33'd1 << PERIOD_BITS) - 33'd1;

    logic [1:0]                      r_state, n_state;
    logic [acia_pkg::CLOCK_BITS-1:0] r_clock_hz;
    logic [1:0]                      r_irq_kind;
    logic [1:0]                      r_sel;
    logic [7:0]                      r_wdata;
    logic                            r_out_valid;
    logic [7:0]                      r_read_data;
    logic                            r_tx_valid;
    logic [7:0]                      r_tx_byte;
    logic                            r_rx_taken;
    logic                            r_irq_out;
    logic                            r_nmi_out;

    logic                              w_in_acc;
    logic                              w_complete;
    logic                              w_div_start;
    logic                              w_div_busy;
    logic                              w_div_done;
    logic [acia_pkg::DIVIDEND_BITS-1:0] w_dividend;
    logic [acia_pkg::DIVIDEND_BITS-1:0] w_quotient;
    logic [32:0]                       w_q_ext;
    logic [PERIOD_BITS-1:0]            w_period;
    acia_pkg::t_core_cmd               w_cmd;
    acia_pkg::t_core_rsp               w_rsp;

    assign o_stall  = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_in_acc = i_valid && !o_stall;

    assign w_dividend = acia_pkg::DIVIDEND_BITS'(r_clock_hz) *
                        acia_pkg::DIVIDEND_BITS'(acia_pkg::CENTI_SCALE);
    assign w_q_ext    = 33'(w_quotient);
    assign w_period   = (w_q_ext > PERIOD_MAX) ? PERIOD_MAX[PERIOD_BITS-1:0]
                                               : w_q_ext[PERIOD_BITS-1:0];

    acia_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (acia_pkg::baud_centi(i_write_data[3:0])),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    acia_regs #(
        .PERIOD_BITS (PERIOD_BITS)
    ) u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_period (w_period),
        .o_rsp    (w_rsp)
    );

    always_comb begin
        w_cmd          = '0;
        w_cmd.op       = acia_pkg::OP_NONE;
        w_cmd.rx_valid = i_rx_valid;
        w_cmd.rx_byte  = i_rx_byte;
        w_complete     = 1'b0;
        w_div_start    = 1'b0;
        n_state        = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_cmd.sel = i_reg_select;
                    case (i_mode)
                        acia_pkg::MODE_READ: begin
                            w_cmd.op   = acia_pkg::OP_READ;
                            w_complete = 1'b1;
                        end
                        acia_pkg::MODE_TICK: begin
                            w_cmd.op   = acia_pkg::OP_TICK;
                            w_complete = 1'b1;
                        end
                        acia_pkg::MODE_WRITE: begin
                            w_cmd.op = acia_pkg::OP_STORE;
                            if (i_reg_select == acia_pkg::REG_CONTROL) begin
                                // the control byte is stored now and the divider starts on its low four bits
                                w_cmd.data  = i_write_data;
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end else if (i_rmw) begin
                                w_cmd.data  = w_rsp.last_read;
                                w_cmd.early = 1'b1;
                                n_state     = S_STORE2;
                            end else begin
                                w_cmd.data = i_write_data;
                                w_complete = 1'b1;
                            end
                        end
                        default: w_complete = 1'b1;
                    endcase
                end
            end
            S_STORE2: begin
                w_cmd.op   = acia_pkg::OP_STORE;
                w_cmd.sel  = r_sel;
                w_cmd.data = r_wdata;
                w_complete = 1'b1;
                n_state    = S_IDLE;
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_cmd.op   = acia_pkg::OP_PERIOD;
                    w_complete = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock_hz  <= acia_pkg::CLOCK_RESET;
            r_irq_kind  <= acia_pkg::IRQ_KIND_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == acia_pkg::CFG_CLOCK_HZ) begin
                    r_clock_hz <= i_cfg_data;
                end else if (i_cfg_idx == acia_pkg::CFG_IRQ_KIND) begin
                    r_irq_kind <= i_cfg_data[1:0];
                end
            end
            if (w_complete) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sel   <= i_reg_select;
            r_wdata <= i_write_data;
        end
        if (w_complete) begin
            r_read_data <= w_rsp.read_data;
            r_tx_valid  <= w_rsp.tx_valid;
            r_tx_byte   <= w_rsp.tx_byte;
            r_rx_taken  <= w_rsp.rx_taken;
            r_irq_out   <= w_rsp.irq_next && (r_irq_kind == acia_pkg::IRQ_KIND_IRQ);
            r_nmi_out   <= w_rsp.irq_next && (r_irq_kind == acia_pkg::IRQ_KIND_NMI);
        end
    end

    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_rx_taken  = r_rx_taken;
    assign o_irq_out   = r_irq_out;
    assign o_nmi_out   = r_nmi_out;

    `ACIA_ASSERT_NEXT(a_ctrl_starts_div, w_in_acc && (i_mode == acia_pkg::MODE_WRITE) && (i_reg_select == acia_pkg::REG_CONTROL), w_div_busy)
    `ACIA_ASSERT_NEXT(a_store2_gives_word, r_state == S_STORE2, r_out_valid)
    `ACIA_ASSERT_NOW(a_div_only_in_div, w_div_busy || w_div_done, r_state == S_DIV)
    `ACIA_ASSERT_NOW(a_one_irq_line, o_valid, !(o_irq_out && o_nmi_out))
endmodule
`default_nettype wire
